[sv/fbb_pkg.sv]
// Shared types, constants and register codes for the LED fade/blink/breathe block.
package fbb_pkg;

  localparam int unsigned FadePeriod = 10;
  localparam int unsigned CfgAddrW   = 5;
  localparam int unsigned CfgDataW   = 32;

  // floor(x / 20) as (x * FadeRecip) >> FadeShift, exact for x below 1024
  localparam int unsigned FadeRecip  = 205;
  localparam int unsigned FadeShift  = 12;

  typedef enum logic [2:0] {
    REG_TARGET     = 3'd0,
    REG_MODE       = 3'd1,
    REG_BLINK_CNT  = 3'd2,
    REG_ON_OFF     = 3'd3,
    REG_PAUSE      = 3'd4,
    REG_STEP       = 3'd5,
    REG_BREATHE_LO = 3'd6,
    REG_BREATHE_HI = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_FADE    = 2'd0,
    MODE_BLINK   = 2'd1,
    MODE_BREATHE = 2'd2,
    MODE_IDLE    = 2'd3
  } mode_e;

  typedef struct packed {
    logic [7:0]  target_brightness;
    mode_e       effect_mode;
    logic [7:0]  blink_count;
    logic [15:0] on_off_ticks;
    logic [15:0] pause_ticks;
    logic [7:0]  step_ticks;
    logic [7:0]  breathe_min;
    logic [7:0]  breathe_max;
  } cfg_t;

  typedef struct packed {
    logic [7:0] brightness;
    logic       update;
  } result_t;

  function automatic logic [15:0] sat_tick(input logic [15:0] c, input logic adv);
    logic [16:0] s;
    s = {1'b0, c} + {16'd0, adv};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

[sv/led_fade_blink_breathe.sv]
// Top level of the LED fade/blink/breathe effect block.
// Result path: an accepted request's result is registered in the output register, or in the skid register when held.
// Throughput: one request per cycle while in_stall_o is low; the effect state updates in a single pass.
// in_stall_o rises only when both entries of the output buffer hold results.
// Reset: asynchronous, active low; clears effect state, buffer and registers to defaults.
module led_fade_blink_breathe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          advance_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    brightness_out_o,
  output logic                          update_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbb_pkg::CfgAddrW-1:0]  paddr,
  input  logic [fbb_pkg::CfgDataW-1:0]  pwdata,
  output logic [fbb_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);

  fbb_pkg::cfg_t    cfg;
  fbb_pkg::result_t res, res_out;
  logic             accept, full;

  assign accept     = in_valid_i & ~full;
  assign in_stall_o = full;

  fbb_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  fbb_core u_core (
    .clk_i, .rst_ni,
    .accept_i (accept),
    .advance_i,
    .cfg_i    (cfg),
    .result_o (res)
  );

  fbb_outbuf u_outbuf (
    .clk_i, .rst_ni,
    .push_i  (accept),
    .data_i  (res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res_out)
  );

  assign brightness_out_o = res_out.brightness;
  assign update_o         = res_out.update;

endmodule

[sv/fbb_regs.sv]
// APB-style configuration register file.
module fbb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbb_pkg::CfgAddrW-1:0]  paddr,
  input  logic [fbb_pkg::CfgDataW-1:0]  pwdata,
  output logic [fbb_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output fbb_pkg::cfg_t                 cfg_o
);

  fbb_pkg::cfg_t    cfg_q;
  fbb_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx   = fbb_pkg::reg_idx_e'(paddr[fbb_pkg::CfgAddrW-1:2]);
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_brightness <= 8'd50;
      cfg_q.effect_mode       <= fbb_pkg::MODE_FADE;
      cfg_q.blink_count       <= 8'd4;
      cfg_q.on_off_ticks      <= 16'd50;
      cfg_q.pause_ticks       <= 16'd500;
      cfg_q.step_ticks        <= 8'd45;
      cfg_q.breathe_min       <= 8'd10;
      cfg_q.breathe_max       <= 8'd50;
    end else if (wr_en) begin
      case (idx)
        fbb_pkg::REG_TARGET:     cfg_q.target_brightness <= pwdata[7:0];
        fbb_pkg::REG_MODE:       cfg_q.effect_mode <= fbb_pkg::mode_e'(pwdata[1:0]);
        fbb_pkg::REG_BLINK_CNT:  cfg_q.blink_count <= pwdata[7:0];
        fbb_pkg::REG_ON_OFF:     cfg_q.on_off_ticks <= pwdata[15:0];
        fbb_pkg::REG_PAUSE:      cfg_q.pause_ticks <= pwdata[15:0];
        fbb_pkg::REG_STEP:       cfg_q.step_ticks <= pwdata[7:0];
        fbb_pkg::REG_BREATHE_LO: cfg_q.breathe_min <= pwdata[7:0];
        fbb_pkg::REG_BREATHE_HI: cfg_q.breathe_max <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      fbb_pkg::REG_TARGET:     prdata[7:0]  = cfg_q.target_brightness;
      fbb_pkg::REG_MODE:       prdata[1:0]  = cfg_q.effect_mode;
      fbb_pkg::REG_BLINK_CNT:  prdata[7:0]  = cfg_q.blink_count;
      fbb_pkg::REG_ON_OFF:     prdata[15:0] = cfg_q.on_off_ticks;
      fbb_pkg::REG_PAUSE:      prdata[15:0] = cfg_q.pause_ticks;
      fbb_pkg::REG_STEP:       prdata[7:0]  = cfg_q.step_ticks;
      fbb_pkg::REG_BREATHE_LO: prdata[7:0]  = cfg_q.breathe_min;
      fbb_pkg::REG_BREATHE_HI: prdata[7:0]  = cfg_q.breathe_max;
      default:                 prdata = '0;
    endcase
  end

endmodule

[sv/fbb_core.sv]
// Effect state and the per-tick update: timers, fade step, blink and breathe.
module fbb_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             advance_i,
  input  fbb_pkg::cfg_t    cfg_i,
  output fbb_pkg::result_t result_o
);

  logic [7:0]  level_q, level_d;
  logic [15:0] fade_q, fade_d, toggle_q, toggle_d, pause_q, pause_d, step_q, step_d;
  logic        burst_q, burst_d, lamp_q, lamp_d, falling_q, falling_d;
  logic [7:0]  blinks_q, blinks_d, breathe_q, breathe_d;

  logic [15:0] fade_t, toggle_t, pause_t, step_t;
  logic        fade_fire, up;
  logic [8:0]  fade_num;
  logic [16:0] fade_prod;
  logic [7:0]  fade_step;
  logic        fall_a;

  always_comb begin
    fade_t   = fbb_pkg::sat_tick(fade_q, advance_i);
    toggle_t = fbb_pkg::sat_tick(toggle_q, advance_i);
    pause_t  = fbb_pkg::sat_tick(pause_q, advance_i);
    step_t   = fbb_pkg::sat_tick(step_q, advance_i);

    // fade step: floor(diff/20) upward, ceil(diff/20) downward
    up        = cfg_i.target_brightness > level_q;
    fade_num  = up ? {1'b0, cfg_i.target_brightness - level_q}
                   : {1'b0, level_q - cfg_i.target_brightness} + 9'd19;
    fade_prod = {8'd0, fade_num} * 17'(fbb_pkg::FadeRecip);
    fade_step = 8'(fade_prod >> fbb_pkg::FadeShift);
    fade_fire = fade_t >= 16'(fbb_pkg::FadePeriod);

    fade_d    = fade_fire ? 16'd0 : fade_t;
    level_d   = level_q;
    if (fade_fire && level_q != cfg_i.target_brightness) begin
      level_d = up ? level_q + fade_step : level_q - fade_step;
    end

    toggle_d  = toggle_t;
    pause_d   = pause_t;
    step_d    = step_t;
    burst_d   = burst_q;
    lamp_d    = lamp_q;
    blinks_d  = blinks_q;
    breathe_d = breathe_q;
    falling_d = falling_q;
    result_o  = '0;
    fall_a    = falling_q;

    case (cfg_i.effect_mode)
      fbb_pkg::MODE_FADE: begin
        result_o.brightness = level_d;
        result_o.update     = 1'b1;
      end
      fbb_pkg::MODE_BLINK: begin
        if (burst_q) begin
          if (toggle_t >= cfg_i.on_off_ticks) begin
            toggle_d = '0;
            if (blinks_q >= cfg_i.blink_count) begin
              blinks_d = '0;
              burst_d  = 1'b0;
            end else if (!lamp_q) begin
              result_o.brightness = level_d;
              result_o.update     = 1'b1;
              lamp_d              = 1'b1;
            end else begin
              result_o.update = 1'b1;
              lamp_d          = 1'b0;
              blinks_d        = blinks_q + 8'd1;
            end
          end
        end else if (pause_t >= cfg_i.pause_ticks) begin
          pause_d = '0;
          burst_d = 1'b1;
        end
      end
      fbb_pkg::MODE_BREATHE: begin
        // turn at the limits before stepping
        if (breathe_q == cfg_i.breathe_max && !falling_q) fall_a = 1'b1;
        falling_d = (breathe_q == cfg_i.breathe_min && fall_a) ? 1'b0 : fall_a;
        if (step_t >= {8'd0, cfg_i.step_ticks}) begin
          step_d              = '0;
          breathe_d           = falling_d ? breathe_q - 8'd1 : breathe_q + 8'd1;
          result_o.brightness = breathe_d;
          result_o.update     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= 8'd0;
      fade_q    <= '0;
      toggle_q  <= '0;
      pause_q   <= '0;
      step_q    <= '0;
      burst_q   <= 1'b0;
      lamp_q    <= 1'b0;
      blinks_q  <= '0;
      breathe_q <= 8'd50;
      falling_q <= 1'b1;
    end else if (accept_i) begin
      level_q   <= level_d;
      fade_q    <= fade_d;
      toggle_q  <= toggle_d;
      pause_q   <= pause_d;
      step_q    <= step_d;
      burst_q   <= burst_d;
      lamp_q    <= lamp_d;
      blinks_q  <= blinks_d;
      breathe_q <= breathe_d;
      falling_q <= falling_d;
    end
  end

endmodule

[sv/fbb_outbuf.sv]
// Two-entry result buffer: output register plus skid register.
module fbb_outbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fbb_pkg::result_t data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             stall_i,
  output fbb_pkg::result_t data_o
);

  fbb_pkg::result_t out_q, skid_q;
  logic             out_valid_q, skid_valid_q, pop;

  assign pop     = out_valid_q & ~stall_i;
  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (push_i) begin
      if (!out_valid_q || pop) out_q <= data_i;
      else skid_q <= data_i;
    end
  end

endmodule

[sv/fbb_checker.sv]
// Port-level checks for the LED fade/blink/breathe block, bound to the top level.
module fbb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] brightness_out_o,
  input logic       update_o,
  input logic       pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(brightness_out_o) && $stable(update_o))
    else $error("stalled result changed");

  // no refresh drives a dark level
  a_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !update_o |-> brightness_out_o == 8'd0)
    else $error("brightness nonzero without update");

  // backpressure only with a full output stage
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // an accepted request always leaves a valid output on the next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted request produced no result");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind led_fade_blink_breathe fbb_checker u_fbb_checker (.*);
